FILE: hw/rtl/consistent_hash_ring_lookup_defines.svh
// Assertion macros shared by the ring lookup RTL.
`ifndef CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH
`define CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/chrl_pkg.sv
// Shared types and constants for the consistent hash ring lookup.
package chrl_pkg;

   localparam int MAX_NODES_DEF = 16;

   localparam int OP_W   = 2;
   localparam int HASH_W = 32;
   localparam int ID_W   = 8;
   localparam int ST_W   = 2;
   localparam int ENT_W  = HASH_W + ID_W;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

   typedef struct packed {
      logic eq;
      logic ge;
      logic lt_min;
      logic lt_ceil;
   } cmp_res_type;

endpackage

FILE: hw/rtl/chrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/chrl_cmp.sv
// Shared compare unit: one ring entry against the key and the running bests.
module chrl_cmp (
   input  logic [chrl_pkg::HASH_W-1:0] ent_hash,
   input  logic [chrl_pkg::HASH_W-1:0] key_hash,
   input  logic [chrl_pkg::HASH_W-1:0] min_hash,
   input  logic [chrl_pkg::HASH_W-1:0] ceil_hash,
   output chrl_pkg::cmp_res_type       res
);

   always_comb begin
      res.eq      = (ent_hash == key_hash);
      res.ge      = (ent_hash >= key_hash);
      res.lt_min  = (ent_hash < min_hash);
      res.lt_ceil = (ent_hash < ceil_hash);
   end

endmodule

FILE: hw/rtl/consistent_hash_ring_lookup.sv
// Consistent hash ring lookup: top level with scan sequencer and ring storage.
//
// req channel: one beat carries an operation (add, remove, lookup), a hash and
// a node id. rsp channel: one beat per request with the owner id and a status.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Each request scans all MAX_NODES ring slots through the RAM read port, one
// slot per cycle, feeding a single compare unit; the finish state then writes
// back and loads the response register. One request is in flight at a time,
// so a new request is not accepted until the last one leaves the finish state.
// req_stall is high whenever a request is in progress. A finished response
// waits in the output register; a new request may be accepted while it waits,
// and that request holds in its finish state until the output register frees.
// Reset empties the ring (slot valid bits clear) and drops any pending
// response; slot contents are not cleared and need no clearing pass.
`include "consistent_hash_ring_lookup_defines.svh"

module consistent_hash_ring_lookup #(
   parameter int MAX_NODES = chrl_pkg::MAX_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [chrl_pkg::OP_W-1:0]    req_operation,
   input  logic [chrl_pkg::HASH_W-1:0]  req_hash_value,
   input  logic [chrl_pkg::ID_W-1:0]    req_node_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [chrl_pkg::ID_W-1:0]    rsp_owner_id,
   output logic [chrl_pkg::ST_W-1:0]    rsp_status
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(MAX_NODES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [chrl_pkg::OP_W-1:0]     op_ff, op_in;
   logic [chrl_pkg::HASH_W-1:0]   key_ff, key_in;
   logic [chrl_pkg::ID_W-1:0]     id_ff, id_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          proc_vld_ff, proc_vld_in;
   logic [IW-1:0]                 proc_idx_ff, proc_idx_in;
   logic [MAX_NODES-1:0]          valid_ff, valid_in;

   logic                          match_fnd_ff, match_fnd_in;
   logic [IW-1:0]                 match_idx_ff, match_idx_in;
   logic                          free_fnd_ff, free_fnd_in;
   logic [IW-1:0]                 free_idx_ff, free_idx_in;
   logic                          min_fnd_ff, min_fnd_in;
   logic [chrl_pkg::HASH_W-1:0]   min_hash_ff, min_hash_in;
   logic [chrl_pkg::ID_W-1:0]     min_own_ff, min_own_in;
   logic                          ceil_fnd_ff, ceil_fnd_in;
   logic [chrl_pkg::HASH_W-1:0]   ceil_hash_ff, ceil_hash_in;
   logic [chrl_pkg::ID_W-1:0]     ceil_own_ff, ceil_own_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   logic [chrl_pkg::ID_W-1:0]     rsp_own_ff, rsp_own_in;
   logic [chrl_pkg::ST_W-1:0]     rsp_st_ff, rsp_st_in;

   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [chrl_pkg::ENT_W-1:0]    wr_data;
   logic [chrl_pkg::ENT_W-1:0]    rd_data;
   logic [chrl_pkg::HASH_W-1:0]   ent_hash;
   logic [chrl_pkg::ID_W-1:0]     ent_own;
   logic                          ent_vld;
   chrl_pkg::cmp_res_type         cmp;
   logic                          req_acc;
   logic                          rsp_free;

   assign ent_hash = rd_data[chrl_pkg::ENT_W-1:chrl_pkg::ID_W];
   assign ent_own  = rd_data[chrl_pkg::ID_W-1:0];
   assign ent_vld  = valid_ff[proc_idx_ff];

   chrl_ram #(
      .WIDTH (chrl_pkg::ENT_W),
      .DEPTH (MAX_NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   chrl_cmp u_cmp (
      .ent_hash  (ent_hash),
      .key_hash  (key_ff),
      .min_hash  (min_hash_ff),
      .ceil_hash (ceil_hash_ff),
      .res       (cmp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = proc_idx_ff;
      valid_in     = valid_ff;
      match_fnd_in = match_fnd_ff;
      match_idx_in = match_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      min_fnd_in   = min_fnd_ff;
      min_hash_in  = min_hash_ff;
      min_own_in   = min_own_ff;
      ceil_fnd_in  = ceil_fnd_ff;
      ceil_hash_in = ceil_hash_ff;
      ceil_own_in  = ceil_own_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;
      rsp_own_in   = rsp_own_ff;
      rsp_st_in    = rsp_st_ff;
      wr_en        = 1'b0;
      wr_addr      = match_idx_ff;
      wr_data      = {key_ff, id_ff};

      // scan one slot per cycle, in the cycle after its RAM address is issued
      if (proc_vld_ff) begin
         if (ent_vld) begin
            if (cmp.eq && !match_fnd_ff) begin
               match_fnd_in = 1'b1;
               match_idx_in = proc_idx_ff;
            end
            if (!min_fnd_ff || cmp.lt_min) begin
               min_fnd_in  = 1'b1;
               min_hash_in = ent_hash;
               min_own_in  = ent_own;
            end
            if (cmp.ge && (!ceil_fnd_ff || cmp.lt_ceil)) begin
               ceil_fnd_in  = 1'b1;
               ceil_hash_in = ent_hash;
               ceil_own_in  = ent_own;
            end
         end else if (!free_fnd_ff) begin
            free_fnd_in = 1'b1;
            free_idx_in = proc_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in        = req_operation;
               key_in       = req_hash_value;
               id_in        = req_node_id;
               cnt_in       = '0;
               match_fnd_in = 1'b0;
               free_fnd_in  = 1'b0;
               min_fnd_in   = 1'b0;
               ceil_fnd_in  = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff != LAST_CNT) begin
               proc_vld_in = 1'b1;
               proc_idx_in = cnt_ff[IW-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_own_in = '0;
               rsp_st_in  = chrl_pkg::ST_OK;
               case (op_ff)
                  chrl_pkg::OP_ADD: begin
                     if (match_fnd_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_ff;
                     end else if (free_fnd_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                     end else begin
                        rsp_st_in = chrl_pkg::ST_FULL;
                     end
                  end
                  chrl_pkg::OP_REMOVE: begin
                     if (match_fnd_ff) begin
                        valid_in[match_idx_ff] = 1'b0;
                     end else begin
                        rsp_st_in = chrl_pkg::ST_MISS;
                     end
                  end
                  chrl_pkg::OP_LOOKUP: begin
                     if (!min_fnd_ff) begin
                        rsp_st_in = chrl_pkg::ST_EMPTY;
                     end else if (ceil_fnd_ff) begin
                        rsp_own_in = ceil_own_ff;
                     end else begin
                        rsp_own_in = min_own_ff;
                     end
                  end
                  default: begin
                     rsp_st_in = chrl_pkg::ST_OK;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         proc_vld_ff <= 1'b0;
         valid_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         proc_vld_ff <= proc_vld_in;
         valid_ff    <= valid_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      id_ff        <= id_in;
      proc_idx_ff  <= proc_idx_in;
      match_fnd_ff <= match_fnd_in;
      match_idx_ff <= match_idx_in;
      free_fnd_ff  <= free_fnd_in;
      free_idx_ff  <= free_idx_in;
      min_fnd_ff   <= min_fnd_in;
      min_hash_ff  <= min_hash_in;
      min_own_ff   <= min_own_in;
      ceil_fnd_ff  <= ceil_fnd_in;
      ceil_hash_ff <= ceil_hash_in;
      ceil_own_ff  <= ceil_own_in;
      rsp_own_ff   <= rsp_own_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_owner_id = rsp_own_ff;
   assign rsp_status   = rsp_st_ff;

   `CHRL_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_acc,
      (state_ff == S_SCAN) && (cnt_ff == '0),
      "accepted beat did not start a scan at slot zero")
   `CHRL_ASSERT_NOW(a_scan_cnt_range, clock, reset, state_ff == S_SCAN,
      cnt_ff <= LAST_CNT, "scan counter ran past the last slot")
   `CHRL_ASSERT_NOW(a_proc_only_in_scan, clock, reset, proc_vld_ff,
      (state_ff == S_SCAN) || (state_ff == S_FIN), "slot compare outside a scan")
   `CHRL_ASSERT_NOW(a_nonlookup_owner_zero, clock, reset,
      rsp_vld_ff && (rsp_st_ff != chrl_pkg::ST_OK), rsp_own_ff == '0,
      "error response carries a nonzero owner")
   `CHRL_ASSERT_NOW(a_write_only_at_finish, clock, reset, wr_en,
      (state_ff == S_FIN) && rsp_free, "ring write outside the finish cycle")

endmodule
